[rtl/olt_pkg.sv]
package olt_pkg;

    // Request codes
    localparam logic [1:0] MODE_INS_FRONT = 2'd0;
    localparam logic [1:0] MODE_INS_BACK  = 2'd1;
    localparam logic [1:0] MODE_REMOVE    = 2'd2;
    localparam logic [1:0] MODE_FIND      = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NO_MATCH = 2'd2;

    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef logic [1:0]         t_mode;
    typedef logic [1:0]         t_status;
    typedef logic [VALUE_W-1:0] t_value;

    // Controller to datapath
    typedef struct packed {
        logic    load;       // capture request
        logic    clr_pos;    // restart scan at the front
        logic    inc_pos;    // advance scan position
        logic    rd_next;    // read one place beyond the scan position
        logic    wr_shift;   // write read data back one place toward the front
        logic    ins_front;  // write value before the first entry
        logic    ins_back;   // write value after the last entry
        logic    dec_count;  // drop one entry
        logic    set_result; // capture hit and status
        logic    hit;
        t_status status;
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        t_mode mode;
        logic  full;      // list holds CAPACITY entries
        logic  pos_end;   // scan position has passed the last entry
        logic  next_end;  // no entry beyond the scan position
        logic  match;     // read data equals the requested value
    } t_dp_stat;

endpackage

[rtl/olt_ram.sv]
module olt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/olt_datapath.sv]
module olt_datapath #(
    parameter int CAPACITY = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  olt_pkg::t_dp_cmd  i_cmd,
    input  olt_pkg::t_mode    i_mode,
    input  olt_pkg::t_value   i_value,
    output olt_pkg::t_dp_stat o_stat,
    output logic              o_hit,
    output olt_pkg::t_status  o_status,
    output logic [olt_pkg::COUNT_W-1:0] o_count
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int SW = CW + 1;

    logic [IW-1:0]    r_front;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    r_pos;
    olt_pkg::t_mode   r_mode;
    olt_pkg::t_value  r_value;
    logic             r_hit;
    olt_pkg::t_status r_status;

    logic [IW-1:0]   n_front;
    logic [SW-1:0]   rd_sum;
    logic [SW-1:0]   back_sum;
    logic [IW-1:0]   rd_slot;
    logic [IW-1:0]   back_slot;
    logic [IW-1:0]   shift_slot;
    logic [SW-1:0]   shift_sum;
    logic            we;
    logic [IW-1:0]   waddr;
    olt_pkg::t_value wdata;
    olt_pkg::t_value rdata;

    // Ring slot: front plus offset, folded once (front stays below CAPACITY, offset at most CAPACITY)
    always_comb begin
        rd_sum    = SW'(r_front) + SW'(r_pos) + SW'(i_cmd.rd_next);
        back_sum  = SW'(r_front) + SW'(r_count);
        shift_sum = SW'(r_front) + SW'(r_pos);
        rd_slot    = (rd_sum >= SW'(CAPACITY)) ? IW'(rd_sum - SW'(CAPACITY)) : IW'(rd_sum);
        back_slot  = (back_sum >= SW'(CAPACITY)) ? IW'(back_sum - SW'(CAPACITY))
                                                  : IW'(back_sum);
        shift_slot = (shift_sum >= SW'(CAPACITY)) ? IW'(shift_sum - SW'(CAPACITY))
                                                   : IW'(shift_sum);
        n_front    = (r_front == '0) ? IW'(CAPACITY - 1) : r_front - IW'(1);
    end

    always_comb begin
        we    = i_cmd.ins_front | i_cmd.ins_back | i_cmd.wr_shift;
        waddr = shift_slot;
        wdata = rdata;
        if (i_cmd.ins_front) begin
            waddr = n_front;
            wdata = r_value;
        end else if (i_cmd.ins_back) begin
            waddr = back_slot;
            wdata = r_value;
        end
    end

    olt_ram #(
        .WIDTH(olt_pkg::VALUE_W),
        .DEPTH(CAPACITY)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(rd_slot),
        .o_rdata(rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_count <= '0;
            r_pos   <= '0;
        end else begin
            if (i_cmd.ins_front) begin
                r_front <= n_front;
            end
            if (i_cmd.ins_front || i_cmd.ins_back) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.dec_count) begin
                r_count <= r_count - CW'(1);
            end
            if (i_cmd.clr_pos) begin
                r_pos <= '0;
            end else if (i_cmd.inc_pos) begin
                r_pos <= r_pos + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_value <= i_value;
        end
        if (i_cmd.set_result) begin
            r_hit    <= i_cmd.hit;
            r_status <= i_cmd.status;
        end
    end

    always_comb begin
        o_stat.mode     = r_mode;
        o_stat.full     = (r_count >= CW'(CAPACITY));
        o_stat.pos_end  = (r_pos >= r_count);
        o_stat.next_end = ((SW'(r_pos) + SW'(1)) >= SW'(r_count));
        o_stat.match    = (rdata == r_value);
    end

    assign o_hit    = r_hit;
    assign o_status = r_status;
    assign o_count  = olt_pkg::COUNT_W'(r_count);

endmodule

[rtl/olt_ctrl.sv]
module olt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  olt_pkg::t_dp_stat i_stat,
    output olt_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_done
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INS  = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CMP  = 3'd3;
    localparam logic [2:0] S_SHRD = 3'd4;
    localparam logic [2:0] S_SHWR = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       is_remove;

    assign is_remove = (i_stat.mode == olt_pkg::MODE_REMOVE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load    = 1'b1;
                    o_cmd.clr_pos = 1'b1;
                    n_state       = S_INS;
                end
            end
            S_INS: begin
                // Inserts finish here; remove and find start scanning
                if (i_stat.mode == olt_pkg::MODE_INS_FRONT ||
                    i_stat.mode == olt_pkg::MODE_INS_BACK) begin
                    o_cmd.set_result = 1'b1;
                    if (i_stat.full) begin
                        o_cmd.status = olt_pkg::ST_FULL;
                    end else begin
                        o_cmd.ins_front = (i_stat.mode == olt_pkg::MODE_INS_FRONT);
                        o_cmd.ins_back  = (i_stat.mode == olt_pkg::MODE_INS_BACK);
                    end
                    n_state = S_DONE;
                end else begin
                    n_state = S_RD;
                end
            end
            S_RD: begin
                if (i_stat.pos_end) begin
                    o_cmd.set_result = 1'b1;
                    o_cmd.status     = is_remove ? olt_pkg::ST_NO_MATCH : olt_pkg::ST_OK;
                    n_state          = S_DONE;
                end else begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                if (i_stat.match) begin
                    if (is_remove) begin
                        n_state = S_SHRD;
                    end else begin
                        o_cmd.set_result = 1'b1;
                        o_cmd.hit        = 1'b1;
                        n_state          = S_DONE;
                    end
                end else begin
                    o_cmd.inc_pos = 1'b1;
                    n_state       = S_RD;
                end
            end
            S_SHRD: begin
                // Pull the next entry forward, or drop the tail when none is left
                if (i_stat.next_end) begin
                    o_cmd.dec_count  = 1'b1;
                    o_cmd.set_result = 1'b1;
                    o_cmd.hit        = 1'b1;
                    n_state          = S_DONE;
                end else begin
                    o_cmd.rd_next = 1'b1;
                    n_state       = S_SHWR;
                end
            end
            S_SHWR: begin
                o_cmd.wr_shift = 1'b1;
                o_cmd.inc_pos  = 1'b1;
                n_state        = S_SHRD;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

endmodule

[rtl/ordered_list_table.sv]
// Ordered list of up to CAPACITY signed 32-bit values held as a ring in one
// single-port-write RAM. A request is taken when start is high and busy is low;
// its one result appears on o_hit, o_status and o_count for the single cycle in
// which o_done is high and must be captured then, as there is no way to stall it.
// An insert goes from acceptance through state S_INS to state S_DONE.
// Find and remove walk the list from the front through the RAM's registered read
// port, with a read state and a compare state per entry compared; a remove then
// moves each later entry one place forward with one read and one write per entry.
// Compares and moves together touch at most CAPACITY entries, and busy falls the
// cycle after o_done.
module ordered_list_table #(
    parameter int CAPACITY = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  olt_pkg::t_mode                    i_mode,
    input  logic signed [olt_pkg::VALUE_W-1:0] i_value,
    output logic                              o_done,
    output logic                              o_hit,
    output olt_pkg::t_status                  o_status,
    output logic [olt_pkg::COUNT_W-1:0]       o_count
);

    olt_pkg::t_dp_cmd  cmd;
    olt_pkg::t_dp_stat stat;

    olt_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (busy),
        .o_done (o_done)
    );

    olt_datapath #(
        .CAPACITY(CAPACITY)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_mode  (i_mode),
        .i_value (olt_pkg::t_value'(i_value)),
        .o_stat  (stat),
        .o_hit   (o_hit),
        .o_status(o_status),
        .o_count (o_count)
    );

endmodule

[tb/sv/tb_ordered_list_table.sv]
`timescale 1ns / 1ps

module tb_ordered_list_table;

    import olt_pkg::*;

    localparam int LIST_DEPTH     = 16;
    localparam int RANDOM_REQS    = 1780;
    localparam int CALM_TAIL      = 150;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4 * LIST_DEPTH + 8;

    typedef struct {
        t_mode  mode;
        t_value value;
    } t_list_req;

    typedef struct {
        logic               hit;
        t_status            status;
        logic [COUNT_W-1:0] count;
    } t_list_result;

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start   = 1'b0;
    logic                       busy;
    t_mode                      i_mode  = MODE_FIND;
    logic signed [VALUE_W-1:0]  i_value = '0;
    logic                       o_done;
    logic                       o_hit;
    t_status                    o_status;
    logic [COUNT_W-1:0]         o_count;

    t_list_req    pending_reqs[$];
    t_list_result expected_results[$];
    t_value       list_contents[$];
    t_value       value_pool[8];

    t_list_result want;
    int           gap_left;
    int           idle_cycles;
    int           errors;
    int           n_accepted;
    int           n_results;
    int           n_hits;
    int           n_full;
    int           n_no_match;
    int           n_empty_seen;
    int           n_full_seen;

    ordered_list_table #(
        .CAPACITY(LIST_DEPTH)
    ) u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_mode   (i_mode),
        .i_value  (i_value),
        .o_done   (o_done),
        .o_hit    (o_hit),
        .o_status (o_status),
        .o_count  (o_count)
    );

    always #1 i_clk = ~i_clk;

    // Apply one request to the shadow list and return the result it must give.
    function automatic t_list_result apply_list_request(t_mode mode, t_value value);
        t_list_result res;
        int           idx;
        res.hit    = 1'b0;
        res.status = ST_OK;
        idx        = -1;
        for (int k = 0; k < list_contents.size(); k++) begin
            if (idx < 0 && list_contents[k] == value) begin
                idx = k;
            end
        end
        case (mode)
            MODE_INS_FRONT, MODE_INS_BACK: begin
                if (list_contents.size() >= LIST_DEPTH) begin
                    res.status = ST_FULL;
                end else if (mode == MODE_INS_FRONT) begin
                    list_contents.push_front(value);
                end else begin
                    list_contents.push_back(value);
                end
            end
            MODE_REMOVE: begin
                if (idx < 0) begin
                    res.status = ST_NO_MATCH;
                end else begin
                    list_contents.delete(idx);
                    res.hit = 1'b1;
                end
            end
            default: begin
                res.hit = (idx >= 0);
            end
        endcase
        res.count = COUNT_W'(list_contents.size());
        return res;
    endfunction

    function automatic t_value pick_value();
        if ($urandom_range(0, 4) == 0) begin
            return t_value'($urandom);
        end
        return value_pool[$urandom_range(0, 7)];
    endfunction

    task automatic add_req(t_mode mode, t_value value);
        t_list_req req;
        req.mode  = mode;
        req.value = value;
        pending_reqs.push_back(req);
    endtask

    // Driver: present pending requests, with random idle bursts between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left = 0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(apply_list_request(i_mode, i_value));
                void'(pending_reqs.pop_front());
                n_accepted++;
            end
            if (start && busy) begin
                // hold the transaction until the block takes it
            end else if (gap_left > 0) begin
                gap_left--;
                start <= 1'b0;
            end else if (pending_reqs.size() > CALM_TAIL && $urandom_range(0, 3) == 0) begin
                gap_left = $urandom_range(0, 4);
                start    <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                start   <= 1'b1;
                i_mode  <= pending_reqs[0].mode;
                i_value <= pending_reqs[0].value;
            end else begin
                start <= 1'b0;
            end
        end
    end

    // Monitor: each done pulse must match the oldest outstanding expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            n_results++;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected result hit=%0b status=%0d count=%0d",
                         $time, o_hit, o_status, o_count);
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (o_hit !== want.hit) begin
                    $display("%0t: hit mismatch, expected %0b actual %0b",
                             $time, want.hit, o_hit);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch, expected %0d actual %0d",
                             $time, want.status, o_status);
                    errors++;
                end
                if (o_count !== want.count) begin
                    $display("%0t: count mismatch, expected %0d actual %0d",
                             $time, want.count, o_count);
                    errors++;
                end
                if (want.hit) n_hits++;
                if (want.status == ST_FULL) n_full++;
                if (want.status == ST_NO_MATCH) n_no_match++;
                if (want.count == 0) n_empty_seen++;
                if (want.count == LIST_DEPTH) n_full_seen++;
            end
        end
    end

    // Watchdog: count cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_done) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int  chunk_left;
        bit  filling;
        int  r;
        t_mode m;

        errors      = 0;
        idle_cycles = 0;
        value_pool  = '{32'sh0000_0000, 32'shFFFF_FFFF, 32'sh0000_0001, 32'sh8000_0000,
                        32'sh7FFF_FFFF, 32'sh5A5A_5A5A, 32'shA5A5_A5A5, 32'sh0000_0007};

        // Directed: empty list, extremes, duplicates, fill to capacity, refusals.
        add_req(MODE_FIND,      32'sh0000_0000);
        add_req(MODE_REMOVE,    32'sh0000_0000);
        add_req(MODE_INS_FRONT, 32'sh8000_0000);
        add_req(MODE_INS_BACK,  32'sh7FFF_FFFF);
        add_req(MODE_INS_FRONT, 32'shFFFF_FFFF);
        add_req(MODE_INS_BACK,  32'sh7FFF_FFFF);
        add_req(MODE_FIND,      32'sh8000_0000);
        add_req(MODE_FIND,      32'sh0001_2345);
        add_req(MODE_REMOVE,    32'sh7FFF_FFFF);
        add_req(MODE_FIND,      32'sh7FFF_FFFF);
        add_req(MODE_REMOVE,    32'sh0001_2345);
        for (int k = 0; k < LIST_DEPTH - 3; k++) begin
            add_req((k % 2) ? MODE_INS_FRONT : MODE_INS_BACK, t_value'(k * 32'h1111_1111));
        end
        add_req(MODE_INS_FRONT, 32'sh0000_0042);
        add_req(MODE_INS_BACK,  32'sh0000_0042);
        add_req(MODE_REMOVE,    t_value'(12 * 32'h1111_1111));
        add_req(MODE_REMOVE,    t_value'(11 * 32'h1111_1111));

        // Random: alternate fill-leaning and drain-leaning stretches.
        chunk_left = 0;
        filling    = 1'b0;
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (chunk_left == 0) begin
                chunk_left = $urandom_range(20, 60);
                filling    = ~filling;
            end
            chunk_left--;
            r = $urandom_range(0, 99);
            if (filling) begin
                m = (r < 35) ? MODE_INS_FRONT : (r < 70) ? MODE_INS_BACK :
                    (r < 85) ? MODE_REMOVE : MODE_FIND;
            end else begin
                m = (r < 15) ? MODE_INS_FRONT : (r < 30) ? MODE_INS_BACK :
                    (r < 75) ? MODE_REMOVE : MODE_FIND;
            end
            add_req(m, pick_value());
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests, %0d results: %0d hits, %0d inserts refused when full,",
                 n_accepted, n_results, n_hits, n_full);
        $display("%0d removes without a match; list seen empty %0d and full %0d times",
                 n_no_match, n_empty_seen, n_full_seen);
        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
